FILE: rtl/gmcp_pkg.sv
// ----------------------------------------------------------------------------
// gmcp_pkg: shared types and constants of the grid minimum cost path block
// Field widths, configuration register indexes, cost limits and the cell
// position record passed from the index counters to the datapath.
// ----------------------------------------------------------------------------
package gmcp_pkg;

  // Payload field widths.
  localparam int CELL_W     = 16;
  localparam int COST_W     = 27;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // Default grid limits.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  typedef logic signed [CELL_W-1:0]     cell_t;
  typedef logic signed [COST_W-1:0]     cost_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ROW_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COL_COUNT = cfg_idx_t'(1);

  // Saturation limits of the path cost.
  localparam cost_t COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam cost_t COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  // Where the accepted cell sits in the grid.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_cell;
  } pos_t;

endpackage

FILE: rtl/gmcp_cell_if.sv
// ----------------------------------------------------------------------------
// gmcp_cell_if: cell cost input channel
// Valid/ready channel carrying one signed grid cell cost per transfer.
// ----------------------------------------------------------------------------
interface gmcp_cell_if;
  import gmcp_pkg::*;

  logic  valid;
  logic  ready;
  cell_t cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink   (input valid, input cell_cost, output ready);
endinterface

FILE: rtl/gmcp_result_if.sv
// ----------------------------------------------------------------------------
// gmcp_result_if: path cost result channel
// Valid/ready channel carrying the path cost of one cell and its final flag.
// ----------------------------------------------------------------------------
interface gmcp_result_if;
  import gmcp_pkg::*;

  logic  valid;
  logic  ready;
  cost_t path_cost;
  logic  final_cell;

  modport source (output valid, output path_cost, output final_cell, input ready);
  modport sink   (input valid, input path_cost, input final_cell, output ready);
endinterface

FILE: rtl/gmcp_cfg_if.sv
// ----------------------------------------------------------------------------
// gmcp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface gmcp_cfg_if;
  import gmcp_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gmcp_front.sv
// ----------------------------------------------------------------------------
// gmcp_front: configuration registers and grid position counters
// Holds the row and column counts, clamps them to the grid limits and tracks
// the row and column of the next cell, advancing on every cell transfer.
// ----------------------------------------------------------------------------
module gmcp_front #(
  parameter  int MAX_COLS = gmcp_pkg::MAX_COLS_DEF,
  parameter  int MAX_ROWS = gmcp_pkg::MAX_ROWS_DEF,
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  gmcp_pkg::cfg_idx_t  cfg_index,
  input  gmcp_pkg::cfg_data_t cfg_data,
  input  logic                cell_accept,
  output gmcp_pkg::pos_t      pos,
  output logic [COL_W-1:0]    column_index
);
  import gmcp_pkg::*;

  cfg_data_t        row_count;
  cfg_data_t        col_count;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             at_last_col;
  logic             cfg_write;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready &&
                     (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

  // A count of zero acts as one; a count above the limit acts as the limit.
  always_comb begin
    if (col_count == '0) begin
      last_col = '0;
    end else if (32'(col_count) > MAX_COLS) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(col_count - 1'b1);
    end
    if (row_count == '0) begin
      last_row = '0;
    end else if (32'(row_count) > MAX_ROWS) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(row_count - 1'b1);
    end
  end

  assign at_last_col   = (column_index == last_col);
  assign pos.first_row = (row_index == '0);
  assign pos.first_col = (column_index == '0);
  assign pos.last_cell = at_last_col && (row_index == last_row);

  // Configuration registers; a valid write of either count restarts the grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= cfg_data_t'(1);
      col_count <= cfg_data_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end
      if (cfg_index == REG_COL_COUNT) begin
        col_count <= cfg_data;
      end
    end
  end

  // Position counters walk the grid in row-major order.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_index    <= '0;
      column_index <= '0;
    end else if (cell_accept) begin
      if (at_last_col) begin
        column_index <= '0;
        row_index    <= pos.last_cell ? '0 : row_index + 1'b1;
      end else begin
        column_index <= column_index + 1'b1;
      end
    end
  end

  // The counters return to the top-left corner after the bottom-right cell.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (cell_accept && pos.last_cell && !cfg_write) |=> (row_index == '0 && column_index == '0))
    else $error("position did not wrap after the last cell");

  // The column never passes the last column in use.
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (!$past(cfg_write) && !$past(rst)) |-> (column_index <= last_col))
    else $error("column index beyond the last column");

  // The row never passes the last row in use.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (!$past(cfg_write) && !$past(rst)) |-> (row_index <= last_row))
    else $error("row index beyond the last row");

endmodule

FILE: rtl/gmcp_line_buf.sv
// ----------------------------------------------------------------------------
// gmcp_line_buf: previous row store
// Single write port and single registered read port holding one cost per
// column of the previous row.
// ----------------------------------------------------------------------------
module gmcp_line_buf #(
  parameter  int DEPTH  = gmcp_pkg::MAX_COLS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output gmcp_pkg::cost_t     rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  gmcp_pkg::cost_t     wr_data
);
  import gmcp_pkg::*;

  cost_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gmcp_core.sv
// ----------------------------------------------------------------------------
// gmcp_core: path cost datapath
// Input register with the line store read, a saturating add over the least of
// the upper, left and upper-left costs that exist, and the result register.
// ----------------------------------------------------------------------------
module gmcp_core #(
  parameter  int MAX_COLS = gmcp_pkg::MAX_COLS_DEF,
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cell_valid,
  output logic             cell_ready,
  input  gmcp_pkg::cell_t  cell_cost,
  input  gmcp_pkg::pos_t   pos,
  input  logic [COL_W-1:0] column_index,
  output logic             out_valid,
  input  logic             out_ready,
  output gmcp_pkg::cost_t  out_path_cost,
  output logic             out_final,
  output logic             rd_en,
  output logic [COL_W-1:0] rd_addr,
  input  gmcp_pkg::cost_t  rd_data,
  output logic             wr_en,
  output logic [COL_W-1:0] wr_addr,
  output gmcp_pkg::cost_t  wr_data
);
  import gmcp_pkg::*;

  logic               s1_valid;
  cell_t              s1_cost;
  pos_t               s1_pos;
  logic [COL_W-1:0]   s1_col;
  logic               fwd;
  cost_t              fwd_cost;
  cost_t              left_cost;
  cost_t              diagonal_cost;
  cost_t              up_cost;
  cost_t              min_ul;
  cost_t              base;
  logic signed [COST_W:0] sum;
  cost_t              cost_next;
  logic               s1_adv;
  logic               accept;

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign cell_ready = !rst && (!s1_valid || s1_adv);
  assign accept     = cell_valid && cell_ready;

  // Line store read for the incoming cell, issued at its transfer.
  assign rd_en   = accept;
  assign rd_addr = column_index;

  // Line store write of the finished cell.
  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = cost_next;

  // Input register; a read of the column being written in the same cycle
  // takes the new value directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost  <= cell_cost;
      s1_pos   <= pos;
      s1_col   <= column_index;
      fwd      <= s1_adv && (s1_col == column_index);
      fwd_cost <= cost_next;
    end
  end

  // Least neighbor cost and saturating add.
  always_comb begin
    up_cost = fwd ? fwd_cost : rd_data;
    min_ul  = (up_cost < left_cost) ? up_cost : left_cost;
    if (diagonal_cost < min_ul) begin
      min_ul = diagonal_cost;
    end
    priority if (s1_pos.first_row && s1_pos.first_col) begin
      base = '0;
    end else if (s1_pos.first_row) begin
      base = left_cost;
    end else if (s1_pos.first_col) begin
      base = up_cost;
    end else begin
      base = min_ul;
    end
    sum = (COST_W+1)'(s1_cost) + (COST_W+1)'(base);
    if (sum[COST_W] != sum[COST_W-1]) begin
      cost_next = sum[COST_W] ? COST_MIN : COST_MAX;
    end else begin
      cost_next = sum[COST_W-1:0];
    end
  end

  // Neighbor registers follow each finished cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cost     <= '0;
      diagonal_cost <= '0;
    end else if (s1_adv) begin
      left_cost     <= cost_next;
      diagonal_cost <= up_cost;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_path_cost <= cost_next;
      out_final     <= s1_pos.last_cell;
    end
  end

endmodule

FILE: rtl/grid_min_cost_path_top.sv
// ----------------------------------------------------------------------------
// grid_min_cost_path_top: streaming minimum cost path over a grid
// Cell costs enter in row-major order on cell_in; for each cell the least
// path cost from the top-left corner leaves on result_out.
// ----------------------------------------------------------------------------
// Usage:
//   cfg carries writes of row_count (index 0) and col_count (index 1); any
//   such write restarts the grid at its top-left cell. Write only while idle.
//   cell_in takes one signed cell cost per transfer; result_out returns one
//   path cost per cell, with final_cell set on the bottom-right cell, after
//   which the next cell starts a new grid.
//   Throughput is one cell per cycle while result_out does not stall. A result
//   passes the input register, where the line store read data arrives, and
//   then the result register, which drives result_out.valid.
//   When result_out stalls, the result register holds; a cell is still taken
//   only while the input register is empty, and cell_in.ready then drops.
//   Reset clears the pipeline, sets both counts to one and the position to
//   the top-left cell. The line store is not cleared: the first row of each
//   grid writes every column that later rows read.
// ----------------------------------------------------------------------------
module grid_min_cost_path_top #(
  parameter int MAX_COLS = gmcp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gmcp_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  gmcp_cfg_if.sink           cfg,
  gmcp_cell_if.sink          cell_in,
  gmcp_result_if.source      result_out
);
  import gmcp_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  pos_t             pos;
  logic [COL_W-1:0] column_index;
  logic             cell_accept;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  cost_t            rd_data;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  cost_t            wr_data;

  assign cell_accept = cell_in.valid && cell_in.ready;

  // Configuration and grid position.
  gmcp_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cell_accept  (cell_accept),
    .pos          (pos),
    .column_index (column_index)
  );

  // Previous row store.
  gmcp_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Cost datapath and result register.
  gmcp_core #(
    .MAX_COLS (MAX_COLS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cell_valid    (cell_in.valid),
    .cell_ready    (cell_in.ready),
    .cell_cost     (cell_in.cell_cost),
    .pos           (pos),
    .column_index  (column_index),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .out_path_cost (result_out.path_cost),
    .out_final     (result_out.final_cell),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

endmodule
